FILE: rtl/hdec_pkg.sv
package hdec_pkg;

    // Byte position within a codeword
    localparam logic [1:0] POS_HIGH  = 2'd0;
    localparam logic [1:0] POS_LOW   = 2'd1;
    localparam logic [1:0] POS_CHECK = 2'd2;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned SYN_W      = 5;
    localparam int unsigned FIFO_DEPTH = 4;

    // Syndrome column for data word bit 15-k
    localparam logic [SYN_W-1:0] DATA_COL [WORD_W] = '{
        5'h03, 5'h05, 5'h06, 5'h07, 5'h09, 5'h0a, 5'h0b, 5'h0c,
        5'h0d, 5'h0e, 5'h0f, 5'h11, 5'h12, 5'h13, 5'h14, 5'h15
    };

endpackage

FILE: rtl/hamming_21_16_byte_stream_decoder_core.sv
// Hamming(21,16) single-error-correcting decoder for a byte stream. Bytes
// arrive as 3-byte codewords: data high, data low, then a check byte whose
// low five bits are the check bits (bits 7..5 are ignored). On the check
// byte the two data bytes are corrected (a syndrome that names a check bit
// or no column leaves them as they are) and both go out as two items, the
// second carrying the input's last flag. A chunk that ends inside a
// codeword emits only that codeword's first byte, marked last. One input
// item is taken per cycle; results leave one per cycle through a result
// queue of FIFO_DEPTH entries, and the input stalls while fewer than two
// entries are free. Results are registered in the queue as the byte that
// produces them is accepted. A stall on the output side fills the queue first
// and then holds off the input until two entries are free again.
module hamming_21_16_byte_stream_decoder_core #(
    parameter int unsigned FIFO_DEPTH = hdec_pkg::FIFO_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [hdec_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                        i_in_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hdec_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_last
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    // Codeword assembly state
    logic [1:0]                  r_pos, n_pos;
    logic [hdec_pkg::BYTE_W-1:0] r_held0, n_held0;
    logic [hdec_pkg::BYTE_W-1:0] r_held1, n_held1;

    // Result queue
    logic [hdec_pkg::BYTE_W-1:0] r_q_byte [FIFO_DEPTH];
    logic                        r_q_last [FIFO_DEPTH];
    logic [PTR_W-1:0]            r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]            r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]            r_count, n_count;

    logic                        in_acc;
    logic                        out_acc;
    logic [1:0]                  push_n;
    logic [hdec_pkg::BYTE_W-1:0] push0_byte, push1_byte;
    logic                        push0_last, push1_last;
    logic [hdec_pkg::BYTE_W-1:0] cor_hi, cor_lo;
    logic [PTR_W-1:0]            wr_ptr1;

    hdec_correct u_correct (
        .i_hi  (r_held0),
        .i_lo  (r_held1),
        .i_chk (i_in_byte),
        .o_hi  (cor_hi),
        .o_lo  (cor_lo)
    );

    // Stall while a full codeword's two results might not fit
    assign o_stall = (r_count > CNT_W'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign o_out_byte = r_q_byte[r_rd_ptr];
    assign o_out_last = r_q_last[r_rd_ptr];

    // Walk the codeword and decide what to push into the queue
    always_comb begin
        n_pos      = r_pos;
        n_held0    = r_held0;
        n_held1    = r_held1;
        push_n     = 2'd0;
        push0_byte = i_in_byte;
        push0_last = 1'b1;
        push1_byte = cor_lo;
        push1_last = i_in_last;
        if (in_acc) begin
            case (r_pos)
                hdec_pkg::POS_LOW: begin
                    n_held1 = i_in_byte;
                    if (i_in_last) begin
                        // Drop the second byte, emit the first as last
                        push_n     = 2'd1;
                        push0_byte = r_held0;
                        n_pos      = hdec_pkg::POS_HIGH;
                    end else begin
                        n_pos = hdec_pkg::POS_CHECK;
                    end
                end
                hdec_pkg::POS_CHECK: begin
                    push_n     = 2'd2;
                    push0_byte = cor_hi;
                    push0_last = 1'b0;
                    n_pos      = hdec_pkg::POS_HIGH;
                end
                default: begin
                    // First byte (the unused code restarts here too)
                    n_held0 = i_in_byte;
                    if (i_in_last) begin
                        push_n = 2'd1;
                        n_pos  = hdec_pkg::POS_HIGH;
                    end else begin
                        n_pos = hdec_pkg::POS_LOW;
                    end
                end
            endcase
        end
    end

    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(push_n);
        n_rd_ptr = out_acc ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(push_n) - CNT_W'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= hdec_pkg::POS_HIGH;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_pos    <= n_pos;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
        if (push_n != 2'd0) begin
            r_q_byte[r_wr_ptr] <= push0_byte;
            r_q_last[r_wr_ptr] <= push0_last;
        end
        if (push_n == 2'd2) begin
            r_q_byte[wr_ptr1] <= push1_byte;
            r_q_last[wr_ptr1] <= push1_last;
        end
    end

    // Queue never overflows
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A check byte with no drain adds exactly two results
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_pos == hdec_pkg::POS_CHECK && !out_acc)
        |=> (r_count == $past(r_count) + CNT_W'(2)))
        else $error("codeword did not queue two results");

    // Any last byte returns assembly to the first position
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_last) |=> (r_pos == hdec_pkg::POS_HIGH))
        else $error("position not restarted after last byte");

    // Position never takes the unused code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("unused byte position");

endmodule

FILE: rtl/hdec_correct.sv
module hdec_correct (
    input  logic [hdec_pkg::BYTE_W-1:0] i_hi,
    input  logic [hdec_pkg::BYTE_W-1:0] i_lo,
    input  logic [hdec_pkg::BYTE_W-1:0] i_chk,
    output logic [hdec_pkg::BYTE_W-1:0] o_hi,
    output logic [hdec_pkg::BYTE_W-1:0] o_lo
);

    logic [hdec_pkg::WORD_W-1:0] word;
    logic [hdec_pkg::WORD_W-1:0] flip;
    logic [hdec_pkg::SYN_W-1:0]  syn;

    assign word = {i_hi, i_lo};

    always_comb begin
        syn = i_chk[hdec_pkg::SYN_W-1:0];
        for (int k = 0; k < hdec_pkg::WORD_W; k++) begin
            if (word[hdec_pkg::WORD_W-1-k]) begin
                syn = syn ^ hdec_pkg::DATA_COL[k];
            end
        end
    end

    // Columns are all nonzero and distinct: at most one bit matches
    always_comb begin
        for (int k = 0; k < hdec_pkg::WORD_W; k++) begin
            flip[hdec_pkg::WORD_W-1-k] = (syn == hdec_pkg::DATA_COL[k]);
        end
    end

    assign o_hi = word[hdec_pkg::WORD_W-1:hdec_pkg::BYTE_W] ^
                  flip[hdec_pkg::WORD_W-1:hdec_pkg::BYTE_W];
    assign o_lo = word[hdec_pkg::BYTE_W-1:0] ^ flip[hdec_pkg::BYTE_W-1:0];

endmodule
